### rtl/core/rct_pkg.sv
`timescale 1ns / 1ps

package rct_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int KEY_BITS_DEF      = 32;
  localparam int COUNT_BITS_DEF    = 16;

  localparam int CMD_BITS    = 2;
  localparam int STATUS_BITS = 2;

  localparam logic [CMD_BITS-1:0] CMD_ADD     = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_QUERY   = 2'd2;

  localparam logic [STATUS_BITS-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_NULL   = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_ABSENT = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_FULL   = 2'd3;

  // control part of the token that walks down the cell row
  typedef struct packed {
    logic                valid;
    logic [CMD_BITS-1:0] cmd;
    logic                hit;       // some cell already served the item
    logic                appended;  // the serving cell took the key as a new entry
  } rct_tok_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } rct_state_t;

endpackage

### rtl/core/rct_cell.sv
`timescale 1ns / 1ps

module rct_cell
  import rct_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int KEY_BITS      = KEY_BITS_DEF,
  parameter int COUNT_BITS    = COUNT_BITS_DEF,
  parameter int IDX           = 0,
  localparam int FILL_BITS    = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [FILL_BITS-1:0]  fill,
  input  rct_tok_t              tok_i,
  input  logic [KEY_BITS-1:0]   key_i,
  input  logic [COUNT_BITS-1:0] cnt_i,
  output rct_tok_t              tok_o,
  output logic [KEY_BITS-1:0]   key_o,
  output logic [COUNT_BITS-1:0] cnt_o
);

  localparam logic [FILL_BITS-1:0] MY_IDX = FILL_BITS'(IDX);

  logic [KEY_BITS-1:0]   entry_key_r;
  logic [COUNT_BITS-1:0] entry_cnt_r;
  logic [COUNT_BITS-1:0] entry_cnt_nxt;

  rct_tok_t              tok_r, tok_nxt;
  logic [KEY_BITS-1:0]   key_r;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;

  logic live, match, take_new;

  // only entries below the fill level hold keys
  assign live     = tok_i.valid && !tok_i.hit;
  assign match    = live && (MY_IDX < fill) && (key_i == entry_key_r);
  assign take_new = live && (MY_IDX == fill) && (tok_i.cmd == CMD_ADD);

  always_comb begin
    entry_cnt_nxt = entry_cnt_r;
    case (tok_i.cmd)
      CMD_ADD: begin
        if (entry_cnt_r != '1) entry_cnt_nxt = entry_cnt_r + 1'b1;
      end
      CMD_RELEASE: begin
        if (entry_cnt_r != '0) entry_cnt_nxt = entry_cnt_r - 1'b1;
      end
      default: entry_cnt_nxt = entry_cnt_r;
    endcase
  end

  always_comb begin
    tok_nxt = tok_i;
    cnt_nxt = cnt_i;
    if (match) begin
      tok_nxt.hit = 1'b1;
      cnt_nxt     = entry_cnt_nxt;
    end else if (take_new) begin
      tok_nxt.hit      = 1'b1;
      tok_nxt.appended = 1'b1;
      cnt_nxt          = COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_i;
    cnt_r <= cnt_nxt;
    if (match) begin
      entry_cnt_r <= entry_cnt_nxt;
    end else if (take_new) begin
      entry_key_r <= key_i;
      entry_cnt_r <= COUNT_BITS'(1);
    end
  end

  assign tok_o = tok_r;
  assign key_o = key_r;
  assign cnt_o = cnt_r;

endmodule

### rtl/core/reference_count_table.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_stall   in_cmd, in_key
// out_     output     out_valid/out_stall out_ref_count, out_status
//
// A non-null item walks the row of TABLE_ENTRIES cells, one cell a cycle, and
// its result is registered off the last cell into out_valid, out_ref_count
// and out_status.
// A null key is answered the cycle after accept.
// One item is in the row at a time; in_stall is high while it walks and while
// a finished result is held by out_stall. Reset empties the table (fill level
// zero); cell contents need no clearing.

module reference_count_table
  import rct_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int KEY_BITS      = KEY_BITS_DEF,
  parameter int COUNT_BITS    = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [CMD_BITS-1:0]    in_cmd,
  input  logic [KEY_BITS-1:0]    in_key,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [COUNT_BITS-1:0]  out_ref_count,
  output logic [STATUS_BITS-1:0] out_status
);

  localparam int FILL_BITS = $clog2(TABLE_ENTRIES + 1);
  localparam logic [FILL_BITS-1:0] FILL_MAX = FILL_BITS'(TABLE_ENTRIES);

  rct_state_t state_r, state_nxt;
  logic [FILL_BITS-1:0] fill_r, fill_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [COUNT_BITS-1:0] out_cnt_r, out_cnt_nxt;
  logic [STATUS_BITS-1:0] out_st_r, out_st_nxt;

  rct_tok_t              tok  [TABLE_ENTRIES+1];
  logic [KEY_BITS-1:0]   keys [TABLE_ENTRIES+1];
  logic [COUNT_BITS-1:0] cnts [TABLE_ENTRIES+1];

  logic     accept;
  rct_tok_t tail;

  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    tok[0]          = '0;
    tok[0].valid    = accept && (in_key != '0);
    tok[0].cmd      = in_cmd;
    keys[0]         = in_key;
    cnts[0]         = '0;
  end

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    rct_cell #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .KEY_BITS     (KEY_BITS),
      .COUNT_BITS   (COUNT_BITS),
      .IDX          (g)
    ) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .fill (fill_r),
      .tok_i(tok[g]),
      .key_i(keys[g]),
      .cnt_i(cnts[g]),
      .tok_o(tok[g+1]),
      .key_o(keys[g+1]),
      .cnt_o(cnts[g+1])
    );
  end

  assign tail = tok[TABLE_ENTRIES];

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_cnt_nxt   = out_cnt_r;
    out_st_nxt    = out_st_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_key == '0) begin
            out_valid_nxt = 1'b1;
            out_cnt_nxt   = '0;
            out_st_nxt    = ST_NULL;
          end else begin
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (tail.valid) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          if (tail.hit) begin
            out_cnt_nxt = cnts[TABLE_ENTRIES];
            out_st_nxt  = ST_OK;
            if (tail.appended && fill_r != FILL_MAX) fill_nxt = fill_r + 1'b1;
          end else begin
            out_cnt_nxt = '0;
            out_st_nxt  = (tail.cmd == CMD_ADD) ? ST_FULL : ST_ABSENT;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_cnt_r <= out_cnt_nxt;
    out_st_r  <= out_st_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_ref_count = out_cnt_r;
  assign out_status    = out_st_r;

endmodule

### test/reference_count_table_tb.sv
`timescale 1ns / 1ps

module reference_count_table_tb;
  import rct_pkg::*;

  localparam int N_ENTRIES = TABLE_ENTRIES_DEF;
  localparam int KEY_W     = KEY_BITS_DEF;
  localparam int CNT_W     = COUNT_BITS_DEF;

  // unused command code, behaves as a query
  localparam logic [CMD_BITS-1:0] CMD_SPARE = 2'd3;

  localparam logic [KEY_W-1:0] SAT_KEY  = 32'h5A5A_A5A5;
  localparam int               POOL_LEN = 20;

  typedef struct packed {
    logic [CMD_BITS-1:0] cmd;
    logic [KEY_W-1:0]    key;
  } ref_req_t;

  typedef struct packed {
    ref_req_t               req;
    logic [CNT_W-1:0]       count;
    logic [STATUS_BITS-1:0] status;
  } ref_result_t;

  logic                   clk;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  logic [CMD_BITS-1:0]    in_cmd    = '0;
  logic [KEY_W-1:0]       in_key    = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [CNT_W-1:0]       out_ref_count;
  logic [STATUS_BITS-1:0] out_status;

  ref_req_t    req_queue[$];
  ref_result_t pending_counts[$];

  // shadow of the table
  logic [KEY_W-1:0] held_key[N_ENTRIES];
  logic [CNT_W-1:0] held_cnt[N_ENTRIES];
  int               held_fill = 0;

  logic [KEY_W-1:0] key_pool[POOL_LEN];

  bit in_taken  = 1'b0;
  bit steady    = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int hold_at   = 32'h7fff_ffff;
  int got_cnt   = 0;
  int err_cnt   = 0;

  reference_count_table #(
    .TABLE_ENTRIES(N_ENTRIES),
    .KEY_BITS     (KEY_W),
    .COUNT_BITS   (CNT_W)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_key       (in_key),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_ref_count(out_ref_count),
    .out_status   (out_status)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Applies one request to the shadow table and returns the count and status it reports.
  function automatic ref_result_t track_ref(logic [CMD_BITS-1:0] cmd, logic [KEY_W-1:0] key);
    ref_result_t r;
    int          slot;
    int          i;
    r.req.cmd = cmd;
    r.req.key = key;
    r.count   = '0;
    r.status  = ST_OK;
    slot      = -1;
    if (key == '0) begin
      r.status = ST_NULL;
    end else begin
      for (i = 0; i < held_fill; i++) begin
        if (slot < 0 && held_key[i] == key) slot = i;
      end
      if (cmd == CMD_ADD) begin
        if (slot >= 0) begin
          if (held_cnt[slot] != '1) held_cnt[slot] = held_cnt[slot] + 1'b1;
          r.count = held_cnt[slot];
        end else if (held_fill < N_ENTRIES) begin
          held_key[held_fill] = key;
          held_cnt[held_fill] = CNT_W'(1);
          held_fill           = held_fill + 1;
          r.count             = CNT_W'(1);
        end else begin
          r.status = ST_FULL;
        end
      end else if (slot < 0) begin
        r.status = ST_ABSENT;
      end else begin
        if (cmd == CMD_RELEASE && held_cnt[slot] != '0) held_cnt[slot] = held_cnt[slot] - 1'b1;
        r.count = held_cnt[slot];
      end
    end
    return r;
  endfunction

  task automatic note_miss(string what, ref_result_t want, longint got_val, longint want_val);
    err_cnt++;
    $display("%0t: %s mismatch (cmd %0d key %h): expected %0d, got %0d", $time, what,
             want.req.cmd, want.req.key, want_val, got_val);
  endtask

  // results are checked before the new item is predicted in the same edge
  always @(posedge clk) begin : check_out
    ref_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got_cnt++;
        if (pending_counts.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected item: expected none, got count %0d status %0d", $time,
                   out_ref_count, out_status);
        end else begin
          want = pending_counts.pop_front();
          if (out_ref_count !== want.count)
            note_miss("ref_count", want, longint'(out_ref_count), longint'(want.count));
          if (out_status !== want.status)
            note_miss("status", want, longint'(out_status), longint'(want.status));
        end
      end
      if (in_valid && !in_stall) begin
        pending_counts.push_back(track_ref(in_cmd, in_key));
        in_taken = 1'b1;
      end
    end
  end

  always @(negedge clk) begin : drive_in
    ref_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (req_queue.size() != 0 && (steady || $urandom_range(99) >= 31)) begin
        nxt = req_queue.pop_front();
        in_cmd   <= nxt.cmd;
        in_key   <= nxt.key;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // one long hold-off lets the block fill up and stall its input
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && got_cnt >= hold_at) begin
      hold_done <= 1'b1;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < 31);
    end
  end

  task automatic queue_req(logic [CMD_BITS-1:0] cmd, logic [KEY_W-1:0] key);
    ref_req_t r;
    r.cmd = cmd;
    r.key = key;
    req_queue.push_back(r);
  endtask

  task automatic wait_drained();
    while (req_queue.size() != 0 || in_valid || pending_counts.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int                  n;
    int                  sel;
    logic [CMD_BITS-1:0] cmd;
    logic [KEY_W-1:0]    key;

    for (n = 0; n < POOL_LEN; n++) begin
      do key_pool[n] = $urandom; while (key_pool[n] == '0);
    end

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // null keys, absent keys, add/release/query and release at zero
    queue_req(CMD_ADD,     '0);
    queue_req(CMD_RELEASE, '0);
    queue_req(CMD_QUERY,   '0);
    queue_req(CMD_SPARE,   '0);
    queue_req(CMD_QUERY,   32'hFFFF_FFFF);
    queue_req(CMD_RELEASE, 32'hFFFF_FFFF);
    queue_req(CMD_SPARE,   32'h0000_0001);
    queue_req(CMD_ADD,     32'h0000_0001);
    queue_req(CMD_ADD,     32'hFFFF_FFFF);
    queue_req(CMD_ADD,     32'h0000_0001);
    queue_req(CMD_QUERY,   32'h0000_0001);
    queue_req(CMD_SPARE,   32'h0000_0001);
    queue_req(CMD_RELEASE, 32'h0000_0001);
    queue_req(CMD_RELEASE, 32'h0000_0001);
    queue_req(CMD_RELEASE, 32'h0000_0001);
    queue_req(CMD_QUERY,   32'h0000_0001);
    queue_req(CMD_ADD,     32'h8000_0000);
    queue_req(CMD_RELEASE, 32'hFFFF_FFFF);
    queue_req(CMD_ADD,     32'h0000_0001);
    wait_drained();

    // back-to-back adds on one key with no idling on either side
    steady = 1'b1;
    for (n = 0; n < 100; n++) queue_req(CMD_ADD, SAT_KEY);
    queue_req(CMD_RELEASE, SAT_KEY);
    queue_req(CMD_ADD,     SAT_KEY);
    queue_req(CMD_ADD,     SAT_KEY);
    queue_req(CMD_QUERY,   SAT_KEY);
    wait_drained();
    steady = 1'b0;

    hold_at = got_cnt + 40;
    for (n = 0; n < 1030; n++) begin
      sel = $urandom_range(99);
      if (sel < 40)      cmd = CMD_ADD;
      else if (sel < 70) cmd = CMD_RELEASE;
      else if (sel < 95) cmd = CMD_QUERY;
      else               cmd = CMD_SPARE;
      sel = $urandom_range(99);
      if (sel < 70) begin
        key = key_pool[$urandom_range(POOL_LEN - 1)];
      end else if (sel < 78) begin
        case ($urandom_range(3))
          0:       key = 32'h0000_0001;
          1:       key = 32'hFFFF_FFFF;
          2:       key = 32'h8000_0000;
          default: key = SAT_KEY;
        endcase
      end else if (sel < 88) begin
        key = '0;
      end else begin
        key = $urandom;
      end
      queue_req(cmd, key);
    end
    wait_drained();

    repeat (40) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
